// File: rtl/kcpi_pkg.sv
// Shared types and constants for the keyframe camera path interpolator.
// No dependencies.
package kcpi_pkg;

	localparam int unsigned VAL_W = 32;

	typedef enum logic [1:0] {
		MODE_KEY  = 2'd0,
		MODE_REF  = 2'd1,
		MODE_TICK = 2'd2,
		MODE_NONE = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_RUN    = 2'd0,
		ST_SCENE  = 2'd1,
		ST_SWITCH = 2'd2,
		ST_HOLD   = 2'd3
	} path_status_t;

	localparam logic [1:0] CFG_COUNT  = 2'd0;
	localparam logic [1:0] CFG_SCENE  = 2'd1;
	localparam logic [1:0] CFG_NEXT   = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOAD,
		S_ADD,
		S_END,
		S_SEARCH,
		S_DIV,
		S_LERP,
		S_MAP,
		S_OUT
	} state_t;

	typedef struct packed {
		logic load_key;
		logic load_ref;
		logic add_time;
		logic end_check;
		logic search_step;
		logic div_start;
		logic div_step;
		logic lerp_step;
		logic map_step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic at_end;
		logic search_done;
		logic div_done;
		logic lerp_done;
		logic map_done;
		logic ref_present;
	} sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
		logic signed [65:0] hi;
		logic signed [65:0] lo;
		hi = 66'sd2147483647;
		lo = -66'sd2147483648;
		if (x > hi) begin
			sat32 = 32'sh7fffffff;
		end else if (x < lo) begin
			sat32 = 32'sh80000000;
		end else begin
			sat32 = x[31:0];
		end
	endfunction

endpackage

// File: rtl/kcpi_ctrl.sv
// Controller state machine of the keyframe camera path interpolator.
// Depends on kcpi_pkg.
module kcpi_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  logic [1:0]        in_mode,
	input  logic              out_free,
	input  kcpi_pkg::sts_t    sts,
	output kcpi_pkg::cmd_t    cmd,
	output logic              busy
);
	import kcpi_pkg::*;

	state_t state_q, state_d;
	logic [1:0] mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q <= 2'd0;
		end else begin
			state_q <= state_d;
			if (in_fire) begin
				mode_q <= in_mode;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (in_fire) begin
					state_d = S_LOAD;
				end
			end
			S_LOAD: begin
				unique case (mode_t'(mode_q))
					MODE_KEY: begin
						cmd.load_key = 1'b1;
						state_d = S_IDLE;
					end
					MODE_REF: begin
						cmd.load_ref = 1'b1;
						state_d = S_IDLE;
					end
					MODE_TICK: begin
						cmd.add_time = 1'b1;
						state_d = S_ADD;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_ADD: begin
				state_d = S_END;
			end
			S_END: begin
				if (sts.at_end) begin
					if (out_free) begin
						cmd.end_check = 1'b1;
						state_d = S_IDLE;
					end
				end else begin
					state_d = S_SEARCH;
				end
			end
			S_SEARCH: begin
				if (sts.search_done) begin
					cmd.div_start = 1'b1;
					state_d = S_DIV;
				end else begin
					cmd.search_step = 1'b1;
				end
			end
			S_DIV: begin
				if (sts.div_done) begin
					state_d = S_LERP;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			S_LERP: begin
				if (sts.lerp_done) begin
					state_d = sts.ref_present ? S_MAP : S_OUT;
				end else begin
					cmd.lerp_step = 1'b1;
				end
			end
			S_MAP: begin
				if (sts.map_done) begin
					state_d = S_OUT;
				end else begin
					cmd.map_step = 1'b1;
				end
			end
			S_OUT: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

// File: rtl/kcpi_datapath.sv
// Datapath of the keyframe camera path interpolator: keyframe store,
// time and segment registers, serial divider, lerp and basis-map multipliers.
// Depends on kcpi_pkg.
module kcpi_datapath #(
	parameter int MAX_KEYS  = 16,
	parameter int FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  kcpi_pkg::cmd_t        cmd,
	output kcpi_pkg::sts_t        sts,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [4:0]            cfg_data,
	input  logic                  in_fire,
	input  logic [3:0]            in_key_index,
	input  logic                  in_flag,
	input  logic [9*32-1:0]       in_vals,
	output logic [6*32-1:0]       pose,
	output logic                  pose_valid,
	output logic [1:0]            path_status
);
	import kcpi_pkg::*;

	localparam int IW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int CW = IW + 1;
	localparam int DIV_STEPS = 32 + FRAC_BITS + 1;
	localparam int DCW = $clog2(DIV_STEPS + 1);

	logic [31:0] key_mem [0:MAX_KEYS-1][0:6];
	logic        key_lerp [0:MAX_KEYS-1];

	logic [4:0] count_cfg_q;
	logic scene_q, next_q;
	logic [31:0] ref_q [0:8];
	logic ref_present_q;
	logic signed [31:0] elapsed_q;
	logic [IW-1:0] seg_q;
	logic [3:0] key_idx_q;
	logic flag_q;
	logic [31:0] vals_q [0:8];

	logic [CW-1:0] n_use;
	logic [CW-1:0] last_idx;
	logic [CW-1:0] nm2;

	always_comb begin
		if (count_cfg_q < 5'd2) begin
			n_use = CW'(2);
		end else if (32'(count_cfg_q) > 32'(MAX_KEYS)) begin
			n_use = CW'(MAX_KEYS);
		end else begin
			n_use = CW'(count_cfg_q);
		end
		last_idx = n_use - CW'(1);
		nm2 = n_use - CW'(2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_cfg_q <= 5'd2;
			scene_q <= 1'b0;
			next_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_COUNT: count_cfg_q <= cfg_data;
				CFG_SCENE: scene_q <= cfg_data[0];
				CFG_NEXT:  next_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			key_idx_q <= in_key_index;
			flag_q <= in_flag;
			for (int i = 0; i < 9; i++) begin
				vals_q[i] <= in_vals[i*32 +: 32];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_key && (32'(key_idx_q) < 32'(MAX_KEYS))) begin
			for (int j = 0; j < 7; j++) begin
				key_mem[IW'(key_idx_q)][j] <= vals_q[j];
			end
			key_lerp[IW'(key_idx_q)] <= flag_q;
		end
	end

	// Segment search, divide and lerp state.
	logic [IW-1:0] k_q;
	logic [IW-1:0] k1;
	logic signed [31:0] t_last, t_next;
	logic seg_done;
	logic [DCW-1:0] dcnt_q;
	logic [63:0] rem_q;
	logic [32+FRAC_BITS-1:0] quo_q;
	logic [32+FRAC_BITS-1:0] dividend_q;
	logic [32:0] den_q;
	logic zero_r_q;
	logic [FRAC_BITS:0] r_q;
	logic [2:0] lcnt_q;
	logic [31:0] lerp_q [0:5];
	logic [2:0] mo_q;
	logic [1:0] mph_q;
	logic map_fin_q;
	logic signed [65:0] acc_q;
	logic [31:0] map_q [0:5];
	logic [31:0] out_q [0:5];

	assign t_last = key_mem[last_idx[IW-1:0]][0];
	assign k1 = k_q + IW'(1);
	assign t_next = key_mem[k1][0];
	assign seg_done = !(CW'(k_q) < nm2 && elapsed_q >= t_next);

	logic signed [32:0] sum33;
	assign sum33 = 33'(elapsed_q) + 33'($signed(vals_q[0]));

	logic [63:0] rem_sh;
	logic [64:0] rem_sub;
	assign rem_sh = {rem_q[62:0], dividend_q[32+FRAC_BITS-1]};
	assign rem_sub = {1'b0, rem_sh} - {32'd0, den_q};

	// Lerp operands.
	logic [2:0] lj;
	logic signed [31:0] la, lb;
	logic signed [32:0] ld;
	logic signed [33+FRAC_BITS+1:0] lprod;
	logic hold_eye;
	assign lj = lcnt_q;
	assign la = key_mem[k_q][3'd1 + lj];
	assign lb = key_mem[k1][3'd1 + lj];
	assign ld = 33'(lb) - 33'(la);
	assign hold_eye = !key_lerp[k_q] && lj < 3'd3;
	assign lprod = (34+FRAC_BITS+1)'(ld) * $signed({1'b0, r_q});

	// Map: 6 outputs, each accumulated from pos, fwd*z and right*x, plus y on axis 1.
	logic [2:0] mo;
	logic [1:0] mph;
	logic [1:0] axis;
	logic signed [31:0] mv, ma;
	logic signed [63:0] mprod;
	assign mo = mo_q;
	assign mph = mph_q;
	assign axis = (mo >= 3'd3) ? 2'(mo - 3'd3) : 2'(mo);
	always_comb begin
		logic [2:0] base;
		base = (mo >= 3'd3) ? 3'd3 : 3'd0;
		if (mph == 2'd1) begin
			mv = ref_q[3 + axis];
			ma = lerp_q[base + 3'd2];
		end else begin
			mv = ref_q[6 + axis];
			ma = lerp_q[base];
		end
	end
	assign mprod = 64'(mv) * 64'(ma);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				ref_q[i] <= '0;
			end
			ref_present_q <= 1'b0;
			elapsed_q <= '0;
			seg_q <= '0;
			pose_valid <= 1'b0;
			path_status <= 2'd0;
		end else begin
			if (cmd.load_ref) begin
				for (int i = 0; i < 9; i++) begin
					ref_q[i] <= vals_q[i];
				end
				ref_present_q <= flag_q;
			end
			if (cmd.add_time) begin
				elapsed_q <= sat32(66'(sum33));
			end
			if (cmd.end_check) begin
				pose_valid <= 1'b0;
				if (scene_q) begin
					path_status <= ST_SCENE;
				end else if (next_q) begin
					path_status <= ST_SWITCH;
					elapsed_q <= '0;
					seg_q <= '0;
				end else begin
					path_status <= ST_HOLD;
				end
			end
			if (cmd.div_start) begin
				seg_q <= k_q;
			end
			if (cmd.emit) begin
				pose_valid <= 1'b1;
				path_status <= ST_RUN;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.add_time) begin
			k_q <= (CW'(seg_q) > nm2) ? nm2[IW-1:0] : seg_q;
		end
		if (cmd.search_step) begin
			k_q <= k1;
		end
		if (cmd.div_start) begin
			logic signed [32:0] num, den;
			num = 33'(elapsed_q) - 33'($signed(key_mem[k_q][0]));
			den = 33'(t_next) - 33'($signed(key_mem[k_q][0]));
			zero_r_q <= (den <= 0) || (num <= 0);
			dividend_q <= {num[31:0], FRAC_BITS'(0)};
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
			dcnt_q <= '0;
			lcnt_q <= '0;
			mo_q <= '0;
			mph_q <= '0;
		end
		if (cmd.div_step) begin
			dcnt_q <= dcnt_q + DCW'(1);
			if (dcnt_q == DCW'(DIV_STEPS - 1)) begin
				if (zero_r_q) begin
					r_q <= '0;
				end else if (quo_q > (32+FRAC_BITS)'(1 << FRAC_BITS)) begin
					r_q <= (FRAC_BITS+1)'(1 << FRAC_BITS);
				end else begin
					r_q <= quo_q[FRAC_BITS:0];
				end
			end else begin
				dividend_q <= dividend_q << 1;
				if (!rem_sub[64]) begin
					rem_q <= rem_sub[63:0];
					quo_q <= {quo_q[32+FRAC_BITS-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[32+FRAC_BITS-2:0], 1'b0};
				end
			end
		end
		if (cmd.lerp_step) begin
			lcnt_q <= lcnt_q + 3'd1;
			if (hold_eye) begin
				lerp_q[lj] <= la;
			end else begin
				lerp_q[lj] <= sat32(66'(la) + 66'(lprod >>> FRAC_BITS));
			end
		end
		if (cmd.map_step) begin
			if (mph_q == 2'd2) begin
				mph_q <= 2'd0;
				mo_q <= (mo_q == 3'd5) ? 3'd0 : mo_q + 3'd1;
			end else begin
				mph_q <= mph_q + 2'd1;
			end
			unique case (mph)
				2'd0: acc_q <= 66'($signed(ref_q[axis]))
					+ ((axis == 2'd1) ? 66'($signed(lerp_q[((mo >= 3'd3) ? 3'd3 : 3'd0)
					+ 3'd1])) : 66'sd0);
				2'd1: acc_q <= acc_q + 66'(mprod >>> FRAC_BITS);
				default: map_q[mo] <= sat32(acc_q + 66'(mprod >>> FRAC_BITS));
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			pose[i*32 +: 32] = out_q[i];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.end_check) begin
			for (int i = 0; i < 6; i++) begin
				out_q[i] <= '0;
			end
		end
		if (cmd.emit) begin
			for (int i = 0; i < 6; i++) begin
				out_q[i] <= ref_present_q ? map_q[i] : lerp_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			map_fin_q <= 1'b0;
		end else if (cmd.map_step && mph == 2'd2 && mo == 3'd5) begin
			map_fin_q <= 1'b1;
		end
	end

	assign sts.at_end = elapsed_q >= t_last;
	assign sts.search_done = seg_done;
	assign sts.div_done = dcnt_q == DCW'(DIV_STEPS);
	assign sts.lerp_done = lcnt_q == 3'd6;
	assign sts.map_done = map_fin_q;
	assign sts.ref_present = ref_present_q;
endmodule

// File: rtl/keyframe_camera_path_interpolator.sv
// Keyframe camera path interpolator top level.
// At path end a result is produced with no search; a pose with 16 keyframes passes a segment
// search of up to 14 steps, a 49-step serial divider and six lerp steps, then the basis
// mapping when a reference is present; a stalled output holds the result back.
// One transaction at a time: a new input is taken only when the block is idle.
// Reset clears control, reference, time and segment; the keyframe store is not.
module keyframe_camera_path_interpolator #(
	parameter int MAX_KEYS  = 16,
	parameter int FRAC_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [4:0]    cfg_data,
	input  logic          s_tvalid,
	output logic          s_tready,
	// key_index[3:0], flag_bit[4], val0..val8 from bit 5 up, pad.
	input  logic [295:0]  s_tdata,
	// mode[1:0].
	input  logic [1:0]    s_tuser,
	output logic          m_tvalid,
	input  logic          m_tready,
	// eye_x, eye_y, eye_z, at_x, at_y, at_z.
	output logic [191:0]  m_tdata,
	// pose_valid[0], path_status[2:1].
	output logic [2:0]    m_tuser
);
	import kcpi_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic busy, in_fire, out_free, mvalid_q;
	logic [6*32-1:0] pose;
	logic pv;
	logic [1:0] ps;

	assign s_tready = !busy;
	assign in_fire = s_tvalid && s_tready;
	assign out_free = !mvalid_q || m_tready;

	kcpi_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_mode(s_tuser),
		.out_free(out_free), .sts(sts), .cmd(cmd), .busy(busy)
	);

	kcpi_datapath #(.MAX_KEYS(MAX_KEYS), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_fire(in_fire), .in_key_index(s_tdata[3:0]), .in_flag(s_tdata[4]),
		.in_vals(s_tdata[292:5]), .pose(pose), .pose_valid(pv), .path_status(ps)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mvalid_q <= 1'b0;
		end else if (cmd.emit || cmd.end_check) begin
			mvalid_q <= 1'b1;
		end else if (m_tready) begin
			mvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = mvalid_q;
	assign m_tdata = pose;
	assign m_tuser = {ps, pv};

	a_emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit || cmd.end_check) |-> out_free)
		else $error("result produced while output held");
	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !in_fire)
		else $error("input accepted while busy");
endmodule
